[sv/obl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants
// Field widths, status and function codes, sync modes, channel payloads
// and the cell command.
// ----------------------------------------------------------------------------
package obl_pkg;
	localparam int LEVELS_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;
	localparam int SIZE_BITS_DEF = 48;
	localparam int ID_BITS = 63;
	localparam int PORT_PRICE_BITS = 32;
	localparam int PORT_SIZE_BITS = 48;
	localparam int COUNT_BITS = 7;

	localparam logic [1:0] FUNC_SNAP = 2'd0;
	localparam logic [1:0] FUNC_HDR = 2'd1;
	localparam logic [1:0] FUNC_BID = 2'd2;
	localparam logic [1:0] FUNC_ASK = 2'd3;

	localparam logic [2:0] ST_APPLIED = 3'd0;
	localparam logic [2:0] ST_ACCEPT = 3'd1;
	localparam logic [2:0] ST_STALE = 3'd2;
	localparam logic [2:0] ST_GAP = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	typedef enum logic [1:0] {
		MODE_AWAIT = 2'd0,
		MODE_APPLY = 2'd1,
		MODE_STALE = 2'd2,
		MODE_GAP = 2'd3
	} mode_t;

	// input item, fields in channel order
	typedef struct packed {
		logic [1:0] func;
		logic [ID_BITS-1:0] first_id;
		logic [ID_BITS-1:0] final_id;
		logic [ID_BITS-1:0] prev_id;
		logic [PORT_PRICE_BITS-1:0] level_price;
		logic [PORT_SIZE_BITS-1:0] level_size;
	} book_in_t;

	// result item, fields in channel order
	typedef struct packed {
		logic [2:0] status;
		logic [PORT_PRICE_BITS-1:0] best_bid_price;
		logic [PORT_SIZE_BITS-1:0] best_bid_size;
		logic [PORT_PRICE_BITS-1:0] best_ask_price;
		logic [PORT_SIZE_BITS-1:0] best_ask_size;
		logic [COUNT_BITS-1:0] bid_levels;
		logic [COUNT_BITS-1:0] ask_levels;
	} book_out_t;

	// command broadcast to every cell of one side
	typedef struct packed {
		logic clear;
		logic act;   // level item for this side
		logic del;   // size is zero
	} cell_cmd_t;
endpackage

[sv/obl_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_stream_if: valid/ready channel
// Carries one payload of type payload_t from source to sink.
// ----------------------------------------------------------------------------
interface obl_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/obl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_cell: one price level of a sorted side
// Compare against the incoming level, then hold, overwrite, shift down
// (insert) or take the lower neighbor (delete).
// ----------------------------------------------------------------------------
module obl_cell #(
	parameter int PRICE_BITS = obl_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS = obl_pkg::SIZE_BITS_DEF,
	parameter bit IS_BID = 1'b1
) (
	input  logic clk,
	input  logic arst_n,
	input  obl_pkg::cell_cmd_t cmd,
	input  logic [PRICE_BITS-1:0] in_price,
	input  logic [SIZE_BITS-1:0] in_size,
	input  logic any_match,   // some cell of the side holds the incoming price
	// neighbor above (better) and below (worse)
	input  logic up_valid,
	input  logic up_ahead,
	input  logic [PRICE_BITS-1:0] up_price,
	input  logic [SIZE_BITS-1:0] up_size,
	input  logic dn_valid,
	input  logic [PRICE_BITS-1:0] dn_price,
	input  logic [SIZE_BITS-1:0] dn_size,
	output logic valid,
	output logic ahead,
	output logic match,
	output logic [PRICE_BITS-1:0] price,
	output logic [SIZE_BITS-1:0] size
);
	logic valid_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [SIZE_BITS-1:0] size_q;
	logic take_new, take_up, take_dn;

	assign valid = valid_q;
	assign price = price_q;
	assign size = size_q;
	assign match = valid_q && (price_q == in_price);
	// held level ranks ahead of the incoming price
	assign ahead = valid_q && (IS_BID ? (price_q > in_price) : (price_q < in_price));

	// insert point is the first cell not ahead; cells below it shift down
	assign take_new = !cmd.del && !any_match && !ahead && up_ahead;
	assign take_up = !cmd.del && !any_match && !ahead && !up_ahead;
	// delete: cells at and below the match take the lower neighbor
	assign take_dn = cmd.del && any_match && !ahead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.act) begin
			if (take_new)
				valid_q <= 1'b1;
			else if (take_up)
				valid_q <= up_valid;
			else if (take_dn)
				valid_q <= dn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.act && !cmd.clear) begin
			if (take_new) begin
				price_q <= in_price;
				size_q <= in_size;
			end else if (take_up) begin
				price_q <= up_price;
				size_q <= up_size;
			end else if (take_dn) begin
				price_q <= dn_price;
				size_q <= dn_size;
			end else if (match && !cmd.del) begin
				size_q <= in_size;
			end
		end
	end
endmodule

[sv/obl_side.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_side: one side of the book as a chain of cells
// Each cell hands its level to its neighbor; the count is kept in a register
// beside the chain and the full status comes from the count.
// ----------------------------------------------------------------------------
module obl_side #(
	parameter int LEVELS = obl_pkg::LEVELS_DEF,
	parameter int PRICE_BITS = obl_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS = obl_pkg::SIZE_BITS_DEF,
	parameter bit IS_BID = 1'b1
) (
	input  logic clk,
	input  logic arst_n,
	input  obl_pkg::cell_cmd_t cmd,
	input  logic [PRICE_BITS-1:0] in_price,
	input  logic [SIZE_BITS-1:0] in_size,
	output logic full_drop,   // full side with no match for the incoming price
	output logic [$clog2(LEVELS+1)-1:0] count,
	output logic top_valid,
	output logic [PRICE_BITS-1:0] top_price,
	output logic [SIZE_BITS-1:0] top_size
);
	localparam int CW = $clog2(LEVELS+1);
	logic [LEVELS-1:0] v, a, m;
	logic [PRICE_BITS-1:0] p [LEVELS];
	logic [SIZE_BITS-1:0] s [LEVELS];
	logic [CW-1:0] count_q;
	logic any_match, full;

	assign any_match = |m;

	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		logic uv, ua, dv;
		logic [PRICE_BITS-1:0] upp, dnp;
		logic [SIZE_BITS-1:0] ups, dns;
		if (i == 0) begin : g_top
			assign uv = 1'b1;
			assign ua = 1'b1;
			assign upp = in_price;
			assign ups = in_size;
		end else begin : g_mid
			assign uv = v[i-1];
			assign ua = a[i-1];
			assign upp = p[i-1];
			assign ups = s[i-1];
		end
		if (i == LEVELS-1) begin : g_bot
			assign dv = 1'b0;
			assign dnp = p[i];
			assign dns = s[i];
		end else begin : g_inner
			assign dv = v[i+1];
			assign dnp = p[i+1];
			assign dns = s[i+1];
		end
		obl_cell #(.PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS), .IS_BID(IS_BID)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.in_price(in_price), .in_size(in_size), .any_match(any_match),
			.up_valid(uv), .up_ahead(ua), .up_price(upp), .up_size(ups),
			.dn_valid(dv), .dn_price(dnp), .dn_size(dns),
			.valid(v[i]), .ahead(a[i]), .match(m[i]), .price(p[i]), .size(s[i])
		);
	end

	assign full = (count_q == CW'(LEVELS));
	assign full_drop = full && !any_match;
	assign count = count_q;
	assign top_valid = v[0];
	assign top_price = p[0];
	assign top_size = s[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.act) begin
			if (cmd.del) begin
				if (any_match) count_q <= count_q - 1'b1;
			end else if (!any_match && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end
endmodule

[sv/order_book_level_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_level_update: two-sided price-level book
// Sequence-checked level book built from two sorted cell chains.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one transfer per item (func, ids, level price and size).
//   out : one transfer per item (status, top of book, level counts).
// Each side is a row of LEVELS cells sorted best first; a level item is
// broadcast to every cell of its side, each cell compares against it and
// then holds, overwrites, takes its upper neighbor (insert) or its lower
// neighbor (delete), all cells on the same clock edge.
// The result is registered and offered in the cycle after the input
// transfer; an item is accepted, then its result is offered, built from the
// cell update followed by the top-of-book read from cell zero.
// A new item is accepted only once the previous result has been taken.
// Reset clears both counts, the last applied id and the sync mode
// (awaiting snapshot); cell contents need no clearing.
// When the receiver stalls the result holds in the output register and
// no further input is accepted until it is taken.
// ----------------------------------------------------------------------------
module order_book_level_update #(
	parameter int LEVELS = obl_pkg::LEVELS_DEF,
	parameter int PRICE_BITS = obl_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS = obl_pkg::SIZE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	obl_stream_if.sink in_ch,
	obl_stream_if.source out_ch
);
	localparam int CW = $clog2(LEVELS+1);

	logic busy_q;   // item accepted, result pending
	logic acc;
	logic [obl_pkg::ID_BITS-1:0] last_id_q;
	obl_pkg::mode_t mode_q;
	logic [2:0] status_q;

	logic [1:0] func;
	logic [obl_pkg::ID_BITS-1:0] first_id, final_id, prev_id;
	logic [PRICE_BITS-1:0] price;
	logic [SIZE_BITS-1:0] size;
	assign func = in_ch.data.func;
	assign first_id = in_ch.data.first_id;
	assign final_id = in_ch.data.final_id;
	assign prev_id = in_ch.data.prev_id;
	assign price = PRICE_BITS'(in_ch.data.level_price);
	assign size = SIZE_BITS'(in_ch.data.level_size);

	assign in_ch.ready = !busy_q;
	assign acc = in_ch.valid && in_ch.ready;

	// command each side
	obl_pkg::cell_cmd_t bid_cmd, ask_cmd;
	logic applying;
	assign applying = (mode_q == obl_pkg::MODE_APPLY);
	always_comb begin
		bid_cmd.clear = acc && (func == obl_pkg::FUNC_SNAP);
		bid_cmd.act = acc && applying && (func == obl_pkg::FUNC_BID);
		bid_cmd.del = (size == '0);
		ask_cmd.clear = bid_cmd.clear;
		ask_cmd.act = acc && applying && (func == obl_pkg::FUNC_ASK);
		ask_cmd.del = bid_cmd.del;
	end

	logic bid_drop, ask_drop, bid_tv, ask_tv;
	logic [CW-1:0] bid_cnt, ask_cnt;
	logic [PRICE_BITS-1:0] bid_tp, ask_tp;
	logic [SIZE_BITS-1:0] bid_ts, ask_ts;

	obl_side #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS),
		.IS_BID(1'b1)) u_bid (
		.clk(clk), .arst_n(arst_n), .cmd(bid_cmd), .in_price(price), .in_size(size),
		.full_drop(bid_drop), .count(bid_cnt), .top_valid(bid_tv),
		.top_price(bid_tp), .top_size(bid_ts)
	);
	obl_side #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS),
		.IS_BID(1'b0)) u_ask (
		.clk(clk), .arst_n(arst_n), .cmd(ask_cmd), .in_price(price), .in_size(size),
		.full_drop(ask_drop), .count(ask_cnt), .top_valid(ask_tv),
		.top_price(ask_tp), .top_size(ask_ts)
	);

	// sequence checking
	logic [obl_pkg::ID_BITS-1:0] next_id;
	logic window, chained;
	assign next_id = last_id_q + 1'b1;
	assign window = (first_id <= next_id) && (next_id <= final_id);
	assign chained = (prev_id == last_id_q) && (prev_id != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_id_q <= '0;
			mode_q <= obl_pkg::MODE_AWAIT;
			status_q <= obl_pkg::ST_IGNORED;
		end else begin
			if (out_ch.valid && out_ch.ready) busy_q <= 1'b0;
			if (acc) begin
				busy_q <= 1'b1;
				case (func)
					obl_pkg::FUNC_SNAP: begin
						last_id_q <= final_id;
						mode_q <= obl_pkg::MODE_APPLY;
						status_q <= obl_pkg::ST_ACCEPT;
					end
					obl_pkg::FUNC_HDR: begin
						if (mode_q == obl_pkg::MODE_AWAIT || mode_q == obl_pkg::MODE_GAP) begin
							mode_q <= obl_pkg::MODE_GAP;
							status_q <= obl_pkg::ST_GAP;
						end else if (final_id <= last_id_q) begin
							mode_q <= obl_pkg::MODE_STALE;
							status_q <= obl_pkg::ST_STALE;
						end else if (window || chained) begin
							last_id_q <= final_id;
							mode_q <= obl_pkg::MODE_APPLY;
							status_q <= obl_pkg::ST_ACCEPT;
						end else begin
							mode_q <= obl_pkg::MODE_GAP;
							status_q <= obl_pkg::ST_GAP;
						end
					end
					default: begin
						// level item: ignored unless applying; full status when an insert finds a full side with no match
						if (!applying) status_q <= obl_pkg::ST_IGNORED;
						else if (size != '0 &&
							((func == obl_pkg::FUNC_BID) ? bid_drop : ask_drop))
							status_q <= obl_pkg::ST_FULL;
						else status_q <= obl_pkg::ST_APPLIED;
					end
				endcase
			end
		end
	end

	// result read straight from cell zero and the counts once they settle
	assign out_ch.valid = busy_q;
	always_comb begin
		out_ch.data.status = status_q;
		out_ch.data.best_bid_price = bid_tv ? obl_pkg::PORT_PRICE_BITS'(bid_tp) : '0;
		out_ch.data.best_bid_size = bid_tv ? obl_pkg::PORT_SIZE_BITS'(bid_ts) : '0;
		out_ch.data.best_ask_price = ask_tv ? obl_pkg::PORT_PRICE_BITS'(ask_tp) : '0;
		out_ch.data.best_ask_size = ask_tv ? obl_pkg::PORT_SIZE_BITS'(ask_ts) : '0;
		out_ch.data.bid_levels = obl_pkg::COUNT_BITS'(bid_cnt);
		out_ch.data.ask_levels = obl_pkg::COUNT_BITS'(ask_cnt);
	end
endmodule
